### rtl/core/drs_pkg.sv
`timescale 1ns / 1ps
package drs_pkg;
  localparam logic CMD_VICTIM = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;
  localparam logic [1:0] RRPV_MAX = 2'd3;
  localparam logic [2:0] REPEAT_MAX = 3'd7;
  localparam logic [0:0] REG_STREAM = 1'b0;
  localparam logic [0:0] REG_REUSE = 1'b1;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_rrpv;
    logic       streaming;
  } result_t;
endpackage

### rtl/core/drs_front.sv
`timescale 1ns / 1ps
module drs_front #(
  parameter int NUM_SETS = 2048,
  parameter int ADDR_BITS = 48,
  parameter int SIG_BITS = 6,
  parameter int LEADERS_EACH = 32,
  parameter int QW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [10:0]                 set_index,
  input  logic [3:0]                  way,
  input  logic [15:0]                 valid_mask,
  input  logic [47:0]                 paddr,
  input  logic [17:0]                 pc_low,
  input  logic                        hit,
  input  logic [4:0]                  random_draw,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [QW-1:0]               q_data
);
  import drs_pkg::*;
  localparam int SW = $clog2(NUM_SETS);
  logic [QW-1:0] buf_data;
  logic          buf_full;
  logic [SW-1:0] set_m;
  logic [SIG_BITS-1:0] sig;
  logic [17:0] pcx;
  logic [ADDR_BITS-1:0] addr;
  logic lead_s, lead_b;

  assign set_m = SW'(set_index % NUM_SETS);
  assign pcx = pc_low ^ (pc_low >> 6) ^ (pc_low >> 12);
  assign sig = SIG_BITS'(pcx);
  assign addr = ADDR_BITS'(paddr);
  assign lead_s = {2'b00, set_m} < (SW+2)'(LEADERS_EACH);
  assign lead_b = !lead_s && ({2'b00, set_m} < (SW+2)'(2 * LEADERS_EACH));

  assign in_ready = !buf_full || q_ready;
  assign q_valid = buf_full;
  assign q_data = buf_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
    end else if (in_ready) begin
      buf_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      buf_data <= {command, set_m, way, valid_mask, addr, sig, hit, random_draw,
                   lead_s, lead_b};
    end
  end
endmodule

### rtl/core/drs_back.sv
`timescale 1ns / 1ps
module drs_back #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int SIG_BITS = 6,
  parameter int PSEL_WIDTH = 10,
  parameter int ADDR_BITS = 48,
  parameter int QW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [QW-1:0]        q_data,
  input  logic [2:0]           stream_threshold,
  input  logic [1:0]           reuse_threshold,
  output logic                 out_valid,
  input  logic                 out_ready,
  output drs_pkg::result_t     res
);
  import drs_pkg::*;
  localparam int SW = $clog2(NUM_SETS);
  localparam int WW = $clog2(NUM_WAYS);
  localparam int SIGN = 1 << SIG_BITS;
  localparam int ROWW = NUM_WAYS * 2;
  localparam int SIGW = NUM_WAYS * SIG_BITS;
  localparam int STW = ADDR_BITS + 1 + ADDR_BITS + 3;
  localparam int CW = (SW > SIG_BITS) ? SW : SIG_BITS;
  localparam int CLR_LAST = ((NUM_SETS > SIGN) ? NUM_SETS : SIGN) - 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DECAY} state_t;
  state_t state;
  logic [CW-1:0] clr_idx;

  logic [ROWW-1:0] rrpv_mem [NUM_SETS];
  logic [SIGW-1:0] sig_mem [NUM_SETS];
  logic [STW-1:0]  str_mem [NUM_SETS];
  logic [1:0] reuse_counter [SIGN];
  logic [ROWW-1:0] rrpv_rd;
  logic [SIGW-1:0] sig_rd;
  logic [STW-1:0]  str_rd;
  logic [1:0] rc_sig, rc_old;
  logic [SIG_BITS-1:0] old_sig_q;
  logic [PSEL_WIDTH-1:0] psel;

  logic                 i_cmd;
  logic [SW-1:0]        i_set;
  logic [3:0]           i_way;
  logic [15:0]          i_mask;
  logic [ADDR_BITS-1:0] i_addr;
  logic [SIG_BITS-1:0]  i_sig;
  logic                 i_hit;
  logic [4:0]           i_draw;
  logic                 i_ls, i_lb;
  logic [QW-1:0]        item;

  assign {i_cmd, i_set, i_way, i_mask, i_addr, i_sig, i_hit, i_draw, i_ls, i_lb} = item;

  assign q_ready = (state == S_IDLE) && (!out_valid || out_ready);

  logic [ADDR_BITS-1:0] l_addr, l_low, n_low;
  logic l_brw, n_brw;
  logic [2:0] l_cnt, n_cnt;
  logic [WW-1:0] w_m;
  logic [1:0] top, add;
  logic [ROWW-1:0] aged;
  logic free_found, max_found;
  logic [WW-1:0] free_w, max_w;
  logic [SIG_BITS-1:0] old_sig;
  logic [1:0] ins;
  logic stream_miss;
  logic [ROWW-1:0] rrpv_wr;
  logic [SIGW-1:0] sig_wr;
  result_t res_next;

  always_comb begin
    {l_low, l_brw, l_addr, l_cnt} = str_rd;
    n_low = i_addr - l_addr;
    n_brw = i_addr < l_addr;
    if ((l_low != '0 || l_brw) && n_low == l_low && n_brw == l_brw)
      n_cnt = (l_cnt < REPEAT_MAX) ? l_cnt + 3'd1 : l_cnt;
    else
      n_cnt = 3'd0;
    w_m = WW'(i_way % NUM_WAYS);
    free_found = 1'b0;
    free_w = '0;
    top = 2'd0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (w < 16 && !free_found && !i_mask[w % 16]) begin
        free_found = 1'b1;
        free_w = WW'(w);
      end
      if (rrpv_rd[2*w +: 2] > top) top = rrpv_rd[2*w +: 2];
    end
    add = RRPV_MAX - top;
    max_found = 1'b0;
    max_w = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[2*w +: 2] = rrpv_rd[2*w +: 2] + add;
      if (!max_found && aged[2*w +: 2] == RRPV_MAX) begin
        max_found = 1'b1;
        max_w = WW'(w);
      end
    end
    old_sig = sig_rd[SIG_BITS*w_m +: SIG_BITS];
    stream_miss = n_cnt >= stream_threshold;
    if (i_ls || (!i_lb && psel[PSEL_WIDTH-1])) ins = 2'd2;
    else ins = (i_draw == 5'd0) ? 2'd2 : 2'd3;
    if (rc_sig >= reuse_threshold) ins = 2'd2;
    if (stream_miss) ins = RRPV_MAX;
    rrpv_wr = rrpv_rd;
    sig_wr = sig_rd;
    res_next = '0;
    if (i_cmd == CMD_VICTIM) begin
      if (!free_found) rrpv_wr = aged;
      res_next.victim_way = 4'(free_found ? free_w : max_w);
    end else if (i_hit) begin
      rrpv_wr[2*w_m +: 2] = 2'd0;
    end else begin
      rrpv_wr[2*w_m +: 2] = ins;
      sig_wr[SIG_BITS*w_m +: SIG_BITS] = i_sig;
      res_next.insert_rrpv = ins;
      res_next.streaming = stream_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      if (int'(clr_idx) < NUM_SETS) begin
        rrpv_mem[clr_idx[SW-1:0]] <= '0;
        sig_mem[clr_idx[SW-1:0]] <= '0;
        str_mem[clr_idx[SW-1:0]] <= '0;
      end
      if (int'(clr_idx) < SIGN) reuse_counter[clr_idx[SIG_BITS-1:0]] <= 2'd0;
    end else if (state == S_EXEC) begin
      rrpv_mem[i_set] <= rrpv_wr;
      sig_mem[i_set] <= sig_wr;
      if (i_cmd == CMD_UPDATE) str_mem[i_set] <= {n_low, n_brw, i_addr, n_cnt};
      if (i_cmd == CMD_UPDATE && i_hit && rc_sig < RRPV_MAX)
        reuse_counter[i_sig] <= rc_sig + 2'd1;
    end else if (state == S_DECAY) begin
      if (i_cmd == CMD_UPDATE && !i_hit && rc_old != 2'd0)
        reuse_counter[old_sig_q] <= rc_old - 2'd1;
    end
    if (state == S_READ) begin
      rrpv_rd <= rrpv_mem[i_set];
      sig_rd <= sig_mem[i_set];
      str_rd <= str_mem[i_set];
      rc_sig <= reuse_counter[i_sig];
    end
    if (state == S_EXEC) begin
      rc_old <= reuse_counter[old_sig];
      old_sig_q <= old_sig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      out_valid <= 1'b0;
      psel <= PSEL_WIDTH'(1) << (PSEL_WIDTH - 1);
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + CW'(1);
          if (clr_idx == CW'(CLR_LAST)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid && q_ready) begin
          item <= q_data;
          state <= S_READ;
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          state <= S_DECAY;
          out_valid <= 1'b1;
          res <= res_next;
          if (i_cmd == CMD_UPDATE && i_hit) begin
            if (i_ls && psel != '1) psel <= psel + PSEL_WIDTH'(1);
            else if (i_lb && psel != '0) psel <= psel - PSEL_WIDTH'(1);
          end
        end
        S_DECAY: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !q_ready) else $error("accept during clear");
  a_exec_follows_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_EXEC) else $error("read not followed by exec");
  a_result_after_exec: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> out_valid) else $error("missing result");
endmodule

### rtl/core/drrip_ship_stream_replacement_core.sv
`timescale 1ns / 1ps
// channel | handshake           | payload
// request | in_valid/in_ready   | command set_index way valid_mask paddr pc_low hit random_draw
// result  | out_valid/out_ready | victim_way insert_rrpv streaming
// config  | APB psel/penable    | apb_paddr pwdata prdata
// A request holds the back end through its steps in order: dequeue, set row and reuse counter read,
// modify and write back, reuse counter decay. The result is registered at the end of the modify
// and write back step; the front buffer holds one request.
// After reset a clearing pass over max(NUM_SETS, 2**SIG_BITS) indices runs before any request.
// Stalls on the result side hold the back end; the front buffer keeps accepting one request.
module drrip_ship_stream_replacement_core #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int SIG_BITS = 6,
  parameter int PSEL_WIDTH = 10,
  parameter int LEADERS_EACH = 32,
  parameter int ADDR_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [10:0] set_index,
  input  logic [3:0]  way,
  input  logic [15:0] valid_mask,
  input  logic [47:0] paddr,
  input  logic [17:0] pc_low,
  input  logic        hit,
  input  logic [4:0]  random_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  victim_way,
  output logic [1:0]  insert_rrpv,
  output logic        streaming,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  apb_paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import drs_pkg::*;
  localparam int SW = $clog2(NUM_SETS);
  localparam int QW = 1 + SW + 4 + 16 + ADDR_BITS + SIG_BITS + 1 + 5 + 2;

  logic [2:0] stream_threshold;
  logic [1:0] reuse_threshold;
  logic q_valid, q_ready;
  logic [QW-1:0] q_data;
  result_t res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_threshold <= 3'd4;
      reuse_threshold <= 2'd2;
    end else if (psel && penable && pwrite && apb_paddr[1:0] == 2'b00) begin
      if (apb_paddr[2] == REG_STREAM) stream_threshold <= pwdata[2:0];
      else reuse_threshold <= pwdata[1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (apb_paddr[1:0] == 2'b00) begin
      if (apb_paddr[2] == REG_STREAM) prdata = {29'd0, stream_threshold};
      else prdata = {30'd0, reuse_threshold};
    end
  end

  drs_front #(.NUM_SETS(NUM_SETS), .ADDR_BITS(ADDR_BITS), .SIG_BITS(SIG_BITS),
    .LEADERS_EACH(LEADERS_EACH), .QW(QW)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .set_index, .way, .valid_mask,
    .paddr, .pc_low, .hit, .random_draw, .q_valid, .q_ready, .q_data);

  drs_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SIG_BITS(SIG_BITS),
    .PSEL_WIDTH(PSEL_WIDTH), .ADDR_BITS(ADDR_BITS), .QW(QW)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .stream_threshold, .reuse_threshold,
    .out_valid, .out_ready, .res);

  assign victim_way = res.victim_way;
  assign insert_rrpv = res.insert_rrpv;
  assign streaming = res.streaming;
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import drs_pkg::*;

  typedef struct {
    logic        command;
    logic [10:0] set_index;
    logic [3:0]  way;
    logic [15:0] valid_mask;
    logic [47:0] paddr;
    logic [17:0] pc_low;
    logic        hit;
    logic [4:0]  random_draw;
  } access_t;

  class replacement_scoreboard;
    logic [1:0]  rrpv[2048][16];
    logic [5:0]  line_sig[2048][16];
    logic [1:0]  reuse_ctr[64];
    logic [47:0] prev_addr[2048];
    logic [48:0] prev_stride[2048];
    logic [2:0]  repeat_cnt[2048];
    logic [9:0]  policy_sel;
    logic [2:0]  stream_thr;
    logic [1:0]  reuse_thr;
    result_t     expected_q[$];
    int          errors;

    function new();
      foreach (rrpv[s, w]) begin
        rrpv[s][w] = 0;
        line_sig[s][w] = 0;
      end
      foreach (reuse_ctr[i]) reuse_ctr[i] = 0;
      foreach (prev_addr[s]) begin
        prev_addr[s] = 0;
        prev_stride[s] = 0;
        repeat_cnt[s] = 0;
      end
      policy_sel = 10'd512;
      stream_thr = 3'd4;
      reuse_thr = 2'd2;
      errors = 0;
    endfunction

    function logic [3:0] choose_victim(int s, logic [15:0] mask);
      logic [1:0] top;
      top = 0;
      for (int w = 0; w < 16; w++)
        if (!mask[w]) return w[3:0];
      for (int w = 0; w < 16; w++)
        if (rrpv[s][w] > top) top = rrpv[s][w];
      for (int w = 0; w < 16; w++)
        rrpv[s][w] = rrpv[s][w] + (RRPV_MAX - top);
      for (int w = 0; w < 16; w++)
        if (rrpv[s][w] == RRPV_MAX) return w[3:0];
      return 4'd0;
    endfunction

    function void note_request(access_t a);
      result_t r;
      int s;
      int w;
      logic [5:0] sig;
      logic [5:0] old_sig;
      logic [48:0] stride;
      logic lead_s;
      logic lead_b;
      logic [1:0] ins;
      r = '0;
      s = a.set_index;
      w = a.way;
      if (a.command == CMD_VICTIM) begin
        r.victim_way = choose_victim(s, a.valid_mask);
        expected_q = {expected_q, r};
        return;
      end
      sig = a.pc_low[5:0] ^ a.pc_low[11:6] ^ a.pc_low[17:12];
      stride = {1'b0, a.paddr} - {1'b0, prev_addr[s]};
      if (prev_stride[s] != 0 && stride == prev_stride[s]) begin
        if (repeat_cnt[s] < REPEAT_MAX) repeat_cnt[s]++;
      end else begin
        repeat_cnt[s] = 0;
      end
      prev_stride[s] = stride;
      prev_addr[s] = a.paddr;
      lead_s = s < 32;
      lead_b = !lead_s && s < 64;
      if (a.hit) begin
        rrpv[s][w] = 0;
        if (reuse_ctr[sig] < RRPV_MAX) reuse_ctr[sig]++;
        if (lead_s && policy_sel != 10'h3ff) policy_sel++;
        else if (lead_b && policy_sel != 0) policy_sel--;
      end else begin
        old_sig = line_sig[s][w];
        if (repeat_cnt[s] >= stream_thr) begin
          ins = RRPV_MAX;
          r.streaming = 1'b1;
        end else begin
          if (lead_s || (!lead_b && policy_sel >= 10'd512)) ins = 2;
          else ins = (a.random_draw == 0) ? 2'd2 : 2'd3;
          if (reuse_ctr[sig] >= reuse_thr) ins = 2;
        end
        rrpv[s][w] = ins;
        if (reuse_ctr[old_sig] > 0) reuse_ctr[old_sig]--;
        line_sig[s][w] = sig;
        r.insert_rrpv = ins;
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.victim_way !== exp_r.victim_way) begin
        $error("victim_way expected %0d got %0d", exp_r.victim_way, got.victim_way);
        errors++;
      end
      if (got.insert_rrpv !== exp_r.insert_rrpv) begin
        $error("insert_rrpv expected %0d got %0d", exp_r.insert_rrpv, got.insert_rrpv);
        errors++;
      end
      if (got.streaming !== exp_r.streaming) begin
        $error("streaming expected %0d got %0d", exp_r.streaming, got.streaming);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic command;
  logic [10:0] set_index;
  logic [3:0] way;
  logic [15:0] valid_mask;
  logic [47:0] paddr;
  logic [17:0] pc_low;
  logic hit;
  logic [4:0] random_draw;
  logic out_valid;
  logic out_ready;
  logic [3:0] victim_way;
  logic [1:0] insert_rrpv;
  logic streaming;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] apb_addr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  replacement_scoreboard sb;
  logic hold_req;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int burst_left;
  int stream_set;
  int stream_len;
  logic [47:0] stream_addr;
  logic [47:0] stream_step;
  logic [17:0] pc_pool[8];

  drrip_ship_stream_replacement_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .set_index(set_index), .way(way), .valid_mask(valid_mask),
    .paddr(paddr), .pc_low(pc_low), .hit(hit), .random_draw(random_draw),
    .out_valid(out_valid), .out_ready(out_ready),
    .victim_way(victim_way), .insert_rrpv(insert_rrpv), .streaming(streaming),
    .psel(psel), .penable(penable), .pwrite(pwrite), .apb_paddr(apb_addr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result('{victim_way, insert_rrpv, streaming});
      if (in_valid && in_ready)
        sb.note_request('{command, set_index, way, valid_mask, paddr, pc_low, hit,
                          random_draw});
    end
  end

  // receiver: random stall pattern, quiet stretches, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ((($time / 800) % 3) == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(access_t a);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= a.command;
    set_index <= a.set_index;
    way <= a.way;
    valid_mask <= a.valid_mask;
    paddr <= a.paddr;
    pc_low <= a.pc_low;
    hit <= a.hit;
    random_draw <= a.random_draw;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    apb_addr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_STREAM) sb.stream_thr = value[2:0];
    else sb.reuse_thr = value[1:0];
  endtask

  function automatic access_t make_update(int s, logic [47:0] a, logic h);
    access_t x;
    x.command = CMD_UPDATE;
    x.set_index = 11'(s);
    x.way = 4'($urandom_range(0, 15));
    x.valid_mask = 16'($urandom);
    x.paddr = a;
    x.pc_low = ($urandom_range(0, 3) == 0) ? 18'($urandom) : pc_pool[$urandom_range(0, 7)];
    x.hit = h;
    x.random_draw = ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom);
    return x;
  endfunction

  function automatic access_t make_victim(int s);
    access_t x;
    x = make_update(s, 48'({$urandom, $urandom}), 1'b0);
    x.command = CMD_VICTIM;
    case ($urandom_range(0, 3))
      0: x.valid_mask = 16'($urandom);
      1: x.valid_mask = 16'hffff ^ (16'h1 << $urandom_range(0, 15));
      default: x.valid_mask = 16'hffff;
    endcase
    return x;
  endfunction

  function automatic int pick_set();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return $urandom_range(32, 63);
      2: return $urandom_range(64, 71);
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic random_item();
    int kind;
    kind = $urandom_range(0, 9);
    if (stream_len > 0) begin
      stream_addr = stream_addr + stream_step;
      stream_len--;
      send(make_update(stream_set, stream_addr, $urandom_range(0, 7) == 0));
    end else if (kind < 3) begin
      stream_set = pick_set();
      stream_len = $urandom_range(3, 14);
      stream_step = ($urandom_range(0, 1)) ? 48'($urandom_range(1, 4096))
                                           : -48'($urandom_range(1, 4096));
      stream_addr = 48'({$urandom, $urandom});
      send(make_update(stream_set, stream_addr, 1'b0));
    end else if (kind < 7) begin
      send(make_update(pick_set(), 48'({$urandom, $urandom}), 1'($urandom_range(0, 1))));
    end else begin
      send(make_victim(pick_set()));
    end
  endtask

  initial begin
    access_t a;
    sb = new();
    hold_req = 1'b0;
    burst_left = 4;
    stream_len = 0;
    foreach (pc_pool[i]) pc_pool[i] = 18'($urandom);
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_VICTIM;
    set_index <= 0;
    way <= 0;
    valid_mask <= 0;
    paddr <= 0;
    pc_low <= 0;
    hit <= 0;
    random_draw <= 0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apb_addr <= 0;
    pwdata <= 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_STREAM, 32'd4);
    write_reg(REG_REUSE, 32'd2);

    // directed
    a = make_victim(0);
    a.valid_mask = 16'h0000;
    send(a);
    a.valid_mask = 16'hffff;
    a.set_index = 11'd2047;
    send(a);
    a.valid_mask = 16'h7fff;
    send(a);
    a.valid_mask = 16'hfffe;
    send(a);
    a = make_update(0, 48'h0, 1'b1);
    a.pc_low = 18'h3ffff;
    send(a);
    a = make_update(32, 48'hffff_ffff_ffff, 1'b1);
    a.pc_low = 18'h0;
    a.way = 4'hf;
    send(a);
    a = make_update(40, 48'h1000, 1'b0);
    a.random_draw = 5'd0;
    send(a);
    a.random_draw = 5'd31;
    a.way = 4'd0;
    send(a);
    for (int i = 0; i < 7; i++) send(make_update(5, 48'h4000 + 48'(i * 64), 1'b0));
    for (int i = 0; i < 6; i++)
      send(make_update(2047, 48'hffff_ffff_ffff - 48'(i * 128), 1'b0));
    a = make_victim(5);
    a.valid_mask = 16'hffff;
    send(a);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin write_reg(REG_STREAM, 32'd0); write_reg(REG_REUSE, 32'd0); end
        1: begin write_reg(REG_STREAM, 32'd7); write_reg(REG_REUSE, 32'd3); end
        2: begin write_reg(REG_STREAM, 32'd2); write_reg(REG_REUSE, 32'd1); end
        3: begin write_reg(REG_STREAM, 32'hffff_fff3); write_reg(REG_REUSE, 32'd2); end
        default: begin write_reg(REG_STREAM, 32'd4); write_reg(REG_REUSE, 32'd2); end
      endcase
      for (int i = 0; i < 240; i++) begin
        if (phase == 1 && i == 20) hold_req = 1'b1;
        random_item();
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
